// ===== design/rdq_pkg.sv =====
package rdq_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int IDX_W  = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
	localparam logic [1:0] FUNC_SEARCH     = 2'd2;

	typedef struct packed {
		logic             done;
		logic             ok;
		logic [IDX_W-1:0] match_index;
	} result_t;

endpackage

// ===== design/rdq_store.sv =====
module rdq_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rdq_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [rdq_pkg::DATA_W-1:0] rdata
);
	import rdq_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rdq_seq.sv =====
module rdq_seq #(
	parameter int PW    = 4,
	parameter int CW    = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 func,
	input  logic [rdq_pkg::DATA_W-1:0] value,
	input  logic                       clr,
	input  logic [CW-1:0]              eff_cap,
	output logic                       busy,
	output logic                       we,
	output logic [PW-1:0]              waddr,
	output logic [rdq_pkg::DATA_W-1:0] wdata,
	output logic [PW-1:0]              raddr,
	input  logic [rdq_pkg::DATA_W-1:0] rdata,
	output rdq_pkg::result_t           res
);
	import rdq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [PW-1:0]     x_s1;
	logic              vld_s1;
	logic [DATA_W-1:0] key_q;
	result_t           res_q;

	logic          accept;
	logic [PW-1:0] cap_m1;
	logic [PW-1:0] head_dec;
	logic [PW-1:0] tail_inc;
	logic          full;
	logic          is_push;
	logic          issue;
	logic          occupied;
	logic          hit;
	logic          last;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign cap_m1   = PW'(eff_cap - CW'(1));
	assign head_dec = (head_q == '0) ? cap_m1 : head_q - PW'(1);
	assign tail_inc = (tail_q == cap_m1) ? '0 : tail_q + PW'(1);
	assign full     = (tail_inc == head_q);
	assign is_push  = (func == FUNC_PUSH_FRONT) || (func == FUNC_PUSH_BACK);

	assign we    = accept && is_push && !full && !clr;
	assign waddr = (func == FUNC_PUSH_FRONT) ? head_dec : tail_q;
	assign wdata = value;

	// one read issued per cycle, compared against the key in the following cycle
	assign issue = (state_q == ST_SCAN) && (rd_cnt_q < eff_cap);
	assign raddr = rd_cnt_q[PW-1:0];

	always_comb begin
		if (head_q <= tail_q) begin
			occupied = (x_s1 >= head_q) && (x_s1 < tail_q);
		end else begin
			occupied = (x_s1 >= head_q) || (x_s1 < tail_q);
		end
	end

	assign hit  = vld_s1 && occupied && (rdata == key_q);
	assign last = vld_s1 && (x_s1 == cap_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
			res_q    <= '0;
		end else begin
			res_q.done <= 1'b0;
			vld_s1     <= issue;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_SEARCH) begin
							state_q  <= ST_SCAN;
							rd_cnt_q <= '0;
							vld_s1   <= 1'b0;
						end else begin
							res_q.done        <= 1'b1;
							res_q.ok          <= is_push && !full;
							res_q.match_index <= '0;
						end
						if (we && (func == FUNC_PUSH_FRONT)) begin
							head_q <= head_dec;
						end
						if (we && (func == FUNC_PUSH_BACK)) begin
							tail_q <= tail_inc;
						end
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						state_q           <= ST_IDLE;
						vld_s1            <= 1'b0;
						res_q.done        <= 1'b1;
						res_q.ok          <= hit;
						res_q.match_index <= hit ? IDX_W'(x_s1) : '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a capacity write empties the list
			if (clr) begin
				head_q <= '0;
				tail_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
		if (issue) begin
			x_s1 <= rd_cnt_q[PW-1:0];
		end
	end

	assign res = res_q;

	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(head_q) < eff_cap)
		else $error("head pointer outside ring");

	a_tail_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(tail_q) < eff_cap)
		else $error("tail pointer outside ring");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |-> (state_q == ST_IDLE))
		else $error("result strobe while scan still running");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= eff_cap))
		else $error("scan counter ran past capacity");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !busy)
		else $error("storage write during scan");

endmodule

// ===== design/ring_deque_with_search.sv =====
// Ring deque of 32-bit words with search by value.
// Command channel: drive func and value with start; the command is taken at
// a rising edge where start is high and busy is low. func selects push
// front, push back or search; the unused code returns ok 0.
// Result channel: done pulses for one cycle with ok and match_index. The
// receiver cannot stall it; a result not sampled in that cycle is gone.
// Push front / push back: result in the cycle after the command, busy stays
// low, so a command may follow every cycle. A push into a full ring (tail+1
// equals head) is dropped with ok 0; capacity-1 words fit.
// Search: reads the storage one slot per cycle through a single read port and
// one 32-bit comparator; the result comes once the last slot is compared, or
// earlier on a hit, and busy is high meanwhile. match_index is the
// lowest occupied slot holding the word.
// Configuration: cfg_data (capacity, clamped to 2..DEPTH) is written when
// cfg_valid and cfg_ready are high; cfg_ready is low during a search. A write
// empties the list. Reset empties the list and sets capacity to 16; stored
// words are not cleared; a search reads them but matches only occupied slots.
module ring_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [rdq_pkg::DATA_W-1:0]  value,
	output logic                        done,
	output logic                        ok,
	output logic [rdq_pkg::IDX_W-1:0]   match_index,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rdq_pkg::CAP_W-1:0]   cfg_data
);
	import rdq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     eff_cap;
	logic              cfg_wr;
	logic              we;
	logic [PW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [PW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;
	result_t           res;

	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		if (cap_q < CAP_W'(2)) begin
			eff_cap = CW'(2);
		end else if (32'(cap_q) > DEPTH) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	rdq_seq #(
		.PW    (PW),
		.CW    (CW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.value   (value),
		.clr     (cfg_wr),
		.eff_cap (eff_cap),
		.busy    (busy),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata   (rdata),
		.res     (res)
	);

	rdq_store #(
		.DEPTH (DEPTH),
		.AW    (PW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done        = res.done;
	assign ok          = res.ok;
	assign match_index = res.match_index;

endmodule
